// File: rtl/ptrm_pkg.sv
// ----------------------------------------------------------------------------
// ptrm_pkg
// shared constants and types of the page table range mapper
// ----------------------------------------------------------------------------
package ptrm_pkg;

  localparam int EXTRA_TABLES      = 16;
  localparam int BOOT_TABLES       = 4;
  localparam int ENTRIES_PER_TABLE = 1024;

  localparam int DIR_COUNT = 1024;
  localparam int DIR_W     = 10;
  localparam int IDX_W     = 10;
  localparam int EXT_W     = (EXTRA_TABLES > 1) ? $clog2(EXTRA_TABLES) : 1;
  localparam int CNT_W     = $clog2(EXTRA_TABLES + 1);
  localparam int TBL_AW    = EXT_W + IDX_W;
  localparam int TBL_DEPTH = EXTRA_TABLES * ENTRIES_PER_TABLE;

  localparam int COUNT_W = 21;
  localparam int SLOT_W  = 5;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 80;

  localparam logic [31:0] PG_PRESENT = 32'h0000_0001;
  localparam logic [31:0] PG_RW      = 32'h0000_0002;
  localparam logic [31:0] PG_BYTES   = 32'd4096;
  localparam logic [31:0] PG_MASK    = 32'hFFFF_F000;

  localparam logic OP_MAP  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic             present;
    logic [EXT_W-1:0] ext;
  } dir_ent_t;

  typedef struct packed {
    logic [31:0]        entry;
    logic [SLOT_W-1:0]  slot;
    logic               present;
    logic [COUNT_W-1:0] skipped;
    logic [COUNT_W-1:0] mapped;
  } result_t;

endpackage

// File: rtl/ptrm_ram.sv
// ----------------------------------------------------------------------------
// ptrm_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module ptrm_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ptrm_alu.sv
// ----------------------------------------------------------------------------
// ptrm_alu
// shared 32-bit adder and unsigned compare used for the range end, the page step and the range check
// ----------------------------------------------------------------------------
module ptrm_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] sum,
  output logic        lt
);

  assign sum = a + b;
  assign lt  = a < b;

endmodule

// File: rtl/ptrm_ctrl.sv
// ----------------------------------------------------------------------------
// ptrm_ctrl
// sequencer that walks a map request page by page and looks up one page for a read
// ----------------------------------------------------------------------------
module ptrm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic                  req_op,
  input  logic [31:0]           req_addr,
  input  logic [31:0]           req_size,
  input  logic                  out_free,
  output logic                  res_valid,
  output ptrm_pkg::result_t     res
);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_END1  = 4'd2;
  localparam logic [3:0] ST_END2  = 4'd3;
  localparam logic [3:0] ST_CHK   = 4'd4;
  localparam logic [3:0] ST_LOOK  = 4'd5;
  localparam logic [3:0] ST_LWAIT = 4'd6;
  localparam logic [3:0] ST_TCLR  = 4'd7;
  localparam logic [3:0] ST_TLINK = 4'd8;
  localparam logic [3:0] ST_NEXT  = 4'd9;
  localparam logic [3:0] ST_RDTAB = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  logic [3:0]                    state;
  logic                          op_r;
  logic [31:0]                   page;
  logic [31:0]                   size_r;
  logic [31:0]                   end_r;
  logic [ptrm_pkg::IDX_W-1:0]    sweep;
  logic [ptrm_pkg::CNT_W-1:0]    alloc_cnt;
  logic [ptrm_pkg::EXT_W-1:0]    alloc_k;
  ptrm_pkg::result_t             res_r;

  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic [31:0] alu_sum;
  logic        alu_lt;
  logic        boot_hit;
  logic [31:0] page_entry;

  logic                           dir_we;
  logic [ptrm_pkg::DIR_W-1:0]     dir_waddr;
  ptrm_pkg::dir_ent_t             dir_wdata;
  logic                           dir_re;
  logic [$bits(ptrm_pkg::dir_ent_t)-1:0] dir_rdata;
  ptrm_pkg::dir_ent_t             dir_rd;

  logic                           tbl_we;
  logic [ptrm_pkg::TBL_AW-1:0]    tbl_waddr;
  logic [31:0]                    tbl_wdata;
  logic                           tbl_re;
  logic [ptrm_pkg::TBL_AW-1:0]    tbl_raddr;
  logic [31:0]                    tbl_rdata;

  assign alloc_k    = alloc_cnt[ptrm_pkg::EXT_W-1:0];
  assign boot_hit   = 32'(page[31:22]) < 32'(ptrm_pkg::BOOT_TABLES);
  assign page_entry = {page[31:12], 12'h000} | ptrm_pkg::PG_PRESENT | ptrm_pkg::PG_RW;
  assign dir_rd     = ptrm_pkg::dir_ent_t'(dir_rdata);
  assign req_ready  = state == ST_IDLE;
  assign res_valid  = (state == ST_FIN) && out_free;
  assign res        = res_r;

  // operand select for the shared adder
  always_comb begin
    case (state)
      ST_END1: begin
        alu_a = page;
        alu_b = size_r;
      end
      ST_END2: begin
        alu_a = end_r;
        alu_b = ptrm_pkg::PG_BYTES - 32'd1;
      end
      ST_CHK: begin
        alu_a = page;
        alu_b = end_r;
      end
      default: begin
        alu_a = page;
        alu_b = ptrm_pkg::PG_BYTES;
      end
    endcase
  end

  ptrm_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .lt  (alu_lt)
  );

  // memory ports
  always_comb begin
    dir_we    = (state == ST_CLR) || (state == ST_TLINK);
    dir_waddr = (state == ST_CLR) ? ptrm_pkg::DIR_W'(sweep) : page[31:22];
    dir_wdata = (state == ST_CLR) ? ptrm_pkg::dir_ent_t'('0) :
                                    ptrm_pkg::dir_ent_t'{present: 1'b1, ext: alloc_k};
    dir_re    = state == ST_LOOK;

    tbl_we    = (state == ST_TCLR) || (state == ST_TLINK) ||
                ((state == ST_LWAIT) && (op_r == ptrm_pkg::OP_MAP) && dir_rd.present);
    if (state == ST_TCLR) begin
      tbl_waddr = {alloc_k, sweep};
      tbl_wdata = ptrm_pkg::PG_RW;
    end else if (state == ST_LWAIT) begin
      tbl_waddr = {dir_rd.ext, page[21:12]};
      tbl_wdata = page_entry;
    end else begin
      tbl_waddr = {alloc_k, page[21:12]};
      tbl_wdata = page_entry;
    end
    tbl_re    = state == ST_LWAIT;
    tbl_raddr = {dir_rd.ext, page[21:12]};
  end

  ptrm_ram #(
    .DATA_W ($bits(ptrm_pkg::dir_ent_t)),
    .DEPTH  (ptrm_pkg::DIR_COUNT)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (page[31:22]),
    .rdata (dir_rdata)
  );

  ptrm_ram #(
    .DATA_W (32),
    .DEPTH  (ptrm_pkg::TBL_DEPTH),
    .ADDR_W (ptrm_pkg::TBL_AW)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      sweep     <= '0;
      alloc_cnt <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          sweep <= sweep + 1'b1;
          if (&sweep) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            op_r          <= req_op;
            page          <= req_addr;
            size_r        <= req_size;
            res_r.mapped  <= '0;
            res_r.skipped <= '0;
            res_r.present <= 1'b0;
            res_r.slot    <= '0;
            res_r.entry   <= (req_op == ptrm_pkg::OP_READ) ? ptrm_pkg::PG_RW : 32'd0;
            state         <= (req_op == ptrm_pkg::OP_READ) ? ST_LOOK : ST_END1;
          end
        end
        ST_END1: begin
          end_r <= alu_sum;
          state <= ST_END2;
        end
        ST_END2: begin
          end_r <= alu_sum & ptrm_pkg::PG_MASK;
          page  <= page & ptrm_pkg::PG_MASK;
          state <= ST_CHK;
        end
        ST_CHK: begin
          state <= alu_lt ? ST_LOOK : ST_FIN;
        end
        ST_LOOK: begin
          if (boot_hit) begin
            if (op_r == ptrm_pkg::OP_MAP) begin
              res_r.mapped <= res_r.mapped + 1'b1;
              state        <= ST_NEXT;
            end else begin
              res_r.present <= 1'b1;
              res_r.slot    <= ptrm_pkg::SLOT_W'(page[31:22]);
              res_r.entry   <= page_entry;
              state         <= ST_FIN;
            end
          end else begin
            state <= ST_LWAIT;
          end
        end
        ST_LWAIT: begin
          if (dir_rd.present) begin
            if (op_r == ptrm_pkg::OP_MAP) begin
              res_r.mapped <= res_r.mapped + 1'b1;
              state        <= ST_NEXT;
            end else begin
              res_r.present <= 1'b1;
              res_r.slot    <= ptrm_pkg::SLOT_W'(32'(ptrm_pkg::BOOT_TABLES) +
                                                 32'(dir_rd.ext));
              state         <= ST_RDTAB;
            end
          end else if (op_r == ptrm_pkg::OP_MAP) begin
            if (alloc_cnt < ptrm_pkg::CNT_W'(ptrm_pkg::EXTRA_TABLES)) begin
              sweep <= '0;
              state <= ST_TCLR;
            end else begin
              res_r.skipped <= res_r.skipped + 1'b1;
              state         <= ST_NEXT;
            end
          end else begin
            state <= ST_FIN;
          end
        end
        ST_TCLR: begin
          sweep <= sweep + 1'b1;
          if (&sweep) begin
            state <= ST_TLINK;
          end
        end
        ST_TLINK: begin
          alloc_cnt    <= alloc_cnt + 1'b1;
          res_r.mapped <= res_r.mapped + 1'b1;
          state        <= ST_NEXT;
        end
        ST_NEXT: begin
          page  <= alu_sum;
          state <= ST_CHK;
        end
        ST_RDTAB: begin
          res_r.entry <= tbl_rdata;
          state       <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/page_table_range_mapper_top.sv
// ----------------------------------------------------------------------------
// page_table_range_mapper_top
// two-level identity page mapper with a directory and a pool of page tables
// ----------------------------------------------------------------------------
// After reset the block sweeps the directory memory and takes no request
// until that is done. A read request is resolved in the lookup step in a boot
// table region, after a registered directory read for an absent directory
// entry, and after that and a further registered table read for an extra table.
// A map request first works out the page-aligned range end, then handles each
// page in turn through the one shared adder and compare unit; a page outside
// the boot table regions also waits on a registered directory read. The result
// is handed over once the output register is free. A page that needs a fresh
// table costs one write per entry into the single-write page table memory and
// one to link the table. One request is worked on at a time; its result sits in
// the output register while the next request is accepted.
module page_table_range_mapper_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ptrm_pkg::IN_W-1:0] s_tdata,   // addr, size
  input  logic                      s_tuser,   // op
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [ptrm_pkg::OUT_W-1:0] m_tdata   // pages_mapped, pages_skipped,
                                               // dir_present, table_slot,
                                               // entry_value
);

  logic              out_free;
  logic              res_valid;
  ptrm_pkg::result_t res;

  assign out_free = !m_tvalid || m_tready;

  ptrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_op    (s_tuser),
    .req_addr  (s_tdata[31:0]),
    .req_size  (s_tdata[63:32]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= ptrm_pkg::OUT_W'(res);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (22'(m_tdata[20:0]) + 22'(m_tdata[41:21])) <= 22'h10_0000)
    else $error("page counts exceed the address space");

  a_read_no_counts: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[42]) |-> (m_tdata[41:0] == 42'd0))
    else $error("read result carries page counts");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while busy");
`endif

endmodule
